// ===== src/cdq_pkg.sv =====
// ----------------------------------------------------------------------------
// cdq_pkg
// shared types, constants and codes of the circular deque
// ----------------------------------------------------------------------------
`default_nettype none

package cdq_pkg;

    localparam int MAX_SLOTS = 64;
    localparam int DATA_BITS = 32;
    localparam int IDX_BITS  = $clog2(MAX_SLOTS);
    localparam int CAP_BITS  = IDX_BITS + 1;
    localparam int CFG_BITS  = 7;
    localparam int CMP_BITS  = (CFG_BITS > CAP_BITS) ? CFG_BITS : CAP_BITS;

    localparam logic [CFG_BITS-1:0] CFG_RESET = CFG_BITS'(64);

    typedef enum logic [2:0] {
        FUNC_NONE       = 3'd0,
        FUNC_PUSH_FRONT = 3'd1,
        FUNC_PUSH_REAR  = 3'd2,
        FUNC_POP_FRONT  = 3'd3,
        FUNC_POP_REAR   = 3'd4
    } t_func;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    typedef struct packed {
        logic [2:0]                  func;
        logic signed [DATA_BITS-1:0] push_value;
    } t_in_item;

    typedef struct packed {
        logic [1:0]                  status;
        logic signed [DATA_BITS-1:0] front_value;
        logic signed [DATA_BITS-1:0] rear_value;
        logic                        is_empty;
        logic                        is_full;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic exec;
        logic rd_en;
        logic load_out;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

// ===== src/circular_deque.sv =====
// ----------------------------------------------------------------------------
// circular_deque
// double-ended queue in a circular slot store with a configurable capacity
// ----------------------------------------------------------------------------
// usage
//   input channel  : i_in_valid / o_in_stall, payload i_in_data (func, push_value)
//   output channel : o_out_valid / i_out_stall, payload o_out_data
//   config channel : i_cfg_valid / o_cfg_ready, i_cfg_data = capacity in use
//   one transaction in gives exactly one transaction out, in order
// timing
//   the accept cycle (S_IDLE) updates the end indices and writes the slot,
//   S_READ reads front and rear slots through the registered read ports of
//   the store, and S_OUT loads the output register once it is free;
//   o_in_stall stays high after an accept until the result is loaded
//   a new operation is taken while the previous result still waits
//   in the output register; only one operation is in flight at a time
// reset
//   synchronous active-low; deque empty, capacity 64, no result pending
//   slot contents are not cleared and need no clearing pass
// back-pressure
//   while i_out_stall holds, the result stays on o_out_data and at most one
//   further operation is taken; it then waits in the load cycle until the
//   output register is free
// config is always ready and must only be written while the block is idle
// ----------------------------------------------------------------------------
`default_nettype none

module circular_deque
    import cdq_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // operation channel
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire t_in_item            i_in_data,
    // result channel
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output t_out_item                o_out_data,
    // capacity register write
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [CFG_BITS-1:0] i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    // sequencer, one operation in flight
    cdq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    // index arithmetic, slot store, result register
    cdq_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    // capacity writes go straight into the capacity register, never refused
    assign o_cfg_ready = 1'b1;

endmodule

`default_nettype wire

// ===== src/cdq_ram.sv =====
// ----------------------------------------------------------------------------
// cdq_ram
// generic ram, one write port, two registered read ports
// ----------------------------------------------------------------------------
`default_nettype none

module cdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_a,
    output logic      [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

`default_nettype wire

// ===== src/cdq_ctrl.sv =====
// ----------------------------------------------------------------------------
// cdq_ctrl
// sequencer: accept, read the end slots, hand the result to the output register
// ----------------------------------------------------------------------------
`default_nettype none

module cdq_ctrl
    import cdq_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_stall,
    output t_cmd      o_cmd,
    input  wire t_sts i_sts
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_OUT  = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("controller state not one-hot");

    a_exec_to_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec |=> (r_state == S_READ))
        else $error("accepted operation not followed by slot read");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> i_sts.out_free)
        else $error("result loaded over an untaken result");

endmodule

`default_nettype wire

// ===== src/cdq_dp.sv =====
// ----------------------------------------------------------------------------
// cdq_dp
// datapath: end indices, capacity register, slot store and output register
// ----------------------------------------------------------------------------
`default_nettype none

module cdq_dp
    import cdq_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_cmd                i_cmd,
    output t_sts                     o_sts,
    input  wire t_in_item            i_in_data,
    input  wire logic                i_cfg_valid,
    input  wire logic [CFG_BITS-1:0] i_cfg_data,
    output logic                     o_out_valid,
    output t_out_item                o_out_data,
    input  wire logic                i_out_stall
);

    function automatic logic [IDX_BITS-1:0] f_step_up(
        input logic [IDX_BITS-1:0] idx,
        input logic [CAP_BITS-1:0] cap
    );
        logic [CAP_BITS-1:0] inc;
        inc = {1'b0, idx} + CAP_BITS'(1);
        f_step_up = (inc >= cap) ? '0 : inc[IDX_BITS-1:0];
    endfunction

    function automatic logic [IDX_BITS-1:0] f_step_down(
        input logic [IDX_BITS-1:0] idx,
        input logic [CAP_BITS-1:0] cap
    );
        logic [CAP_BITS-1:0] dec;
        dec = cap - CAP_BITS'(1);
        if (idx == '0 || {1'b0, idx} > cap) begin
            f_step_down = dec[IDX_BITS-1:0];
        end else begin
            f_step_down = idx - IDX_BITS'(1);
        end
    endfunction

    logic [CFG_BITS-1:0] r_cap_cfg;
    logic [IDX_BITS-1:0] r_head, n_head;
    logic [IDX_BITS-1:0] r_tail, n_tail;
    logic                r_empty, n_empty;
    t_status             r_status, n_status;
    logic                r_out_valid;
    t_out_item           r_out_data;

    logic [CAP_BITS-1:0]  cap;
    logic [IDX_BITS-1:0]  up_head, up_tail, down_head, down_tail;
    logic                 full;
    logic                 we;
    logic [IDX_BITS-1:0]  waddr;
    logic [DATA_BITS-1:0] rd_front, rd_rear;

    // capacity in use, clamped to 1..MAX_SLOTS
    always_comb begin
        if (r_cap_cfg == '0) begin
            cap = CAP_BITS'(1);
        end else if (CMP_BITS'(r_cap_cfg) > CMP_BITS'(MAX_SLOTS)) begin
            cap = CAP_BITS'(MAX_SLOTS);
        end else begin
            cap = CAP_BITS'(r_cap_cfg);
        end
    end

    assign up_head   = f_step_up(r_head, cap);
    assign up_tail   = f_step_up(r_tail, cap);
    assign down_head = f_step_down(r_head, cap);
    assign down_tail = f_step_down(r_tail, cap);
    assign full      = !r_empty && (up_tail == r_head);

    always_comb begin
        n_head   = r_head;
        n_tail   = r_tail;
        n_empty  = r_empty;
        n_status = r_status;
        we       = 1'b0;
        waddr    = r_head;
        if (i_cmd.exec) begin
            n_status = ST_DONE;
            unique case (i_in_data.func)
                FUNC_PUSH_FRONT, FUNC_PUSH_REAR: begin
                    priority if (full) begin
                        n_status = ST_OVERFLOW;
                    end else if (r_empty) begin
                        n_head  = '0;
                        n_tail  = '0;
                        n_empty = 1'b0;
                        we      = 1'b1;
                        waddr   = '0;
                    end else if (i_in_data.func == FUNC_PUSH_FRONT) begin
                        n_head = down_head;
                        we     = 1'b1;
                        waddr  = down_head;
                    end else begin
                        n_tail = up_tail;
                        we     = 1'b1;
                        waddr  = up_tail;
                    end
                end
                FUNC_POP_FRONT, FUNC_POP_REAR: begin
                    priority if (r_empty) begin
                        n_status = ST_UNDERFLOW;
                    end else if (r_head == r_tail) begin
                        n_head  = '0;
                        n_tail  = '0;
                        n_empty = 1'b1;
                    end else if (i_in_data.func == FUNC_POP_FRONT) begin
                        n_head = up_head;
                    end else begin
                        n_tail = down_tail;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap_cfg <= CFG_RESET;
            r_head    <= '0;
            r_tail    <= '0;
            r_empty   <= 1'b1;
        end else begin
            if (i_cfg_valid) begin
                r_cap_cfg <= i_cfg_data;
            end
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_empty <= n_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
    end

    cdq_ram #(
        .WIDTH (DATA_BITS),
        .DEPTH (MAX_SLOTS)
    ) u_slots (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (waddr),
        .i_wdata   (i_in_data.push_value),
        .i_re      (i_cmd.rd_en),
        .i_raddr_a (r_head),
        .i_raddr_b (r_tail),
        .o_rdata_a (rd_front),
        .o_rdata_b (rd_rear)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_data.status      <= r_status;
            r_out_data.front_value <= r_empty ? '0 : rd_front;
            r_out_data.rear_value  <= r_empty ? '0 : rd_rear;
            r_out_data.is_empty    <= r_empty;
            r_out_data.is_full     <= full;
        end
    end

    assign o_sts.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid    = r_out_valid;
    assign o_out_data     = r_out_data;

    a_empty_indices: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_empty |-> (r_head == '0 && r_tail == '0))
        else $error("empty deque with indices away from zero");

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |=> r_out_valid)
        else $error("loaded result not presented");

    a_empty_zero_values: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data.is_empty) |->
        (r_out_data.front_value == '0 && r_out_data.rear_value == '0 &&
         !r_out_data.is_full))
        else $error("empty result carries values or full flag");

endmodule

`default_nettype wire
